[sv/bct_pkg.sv]
// Types and constants shared by the binomial coefficient table.
// Holds the request/result transaction structs and the table memory request struct.
// No dependencies.
package bct_pkg;

  localparam int IDX_W  = 7;
  localparam int COEF_W = 38;
  // Wide enough for n*(n+1)/2 + k with 0 <= k <= n <= 63, the largest table row
  localparam int ADDR_W = 13;

  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
  } bct_in_t;

  typedef struct packed {
    coef_t coefficient;
    logic  out_of_range;
  } bct_out_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    coef_t wdata;
    logic  re;
    addr_t raddr;
  } bct_mem_req_t;

endpackage

[sv/binomial_coefficient_table.sv]
// Binomial coefficient table: returns C(n,k) from a lazily built Pascal triangle.
//
// Request channel: present in_data (row n, column k) with start high; the
// transaction is taken at the rising edge where start is high and busy is low.
// Result channel: out_data is valid for exactly one cycle with out_valid high.
// The receiver cannot stall, so results are never held back.
//
// When row n is already built, the result appears in the cycle after
// acceptance; busy stays high until it is out, so a new request is never
// taken while one is in flight.
// Invalid requests (k > n or n > MAX_ROW) go straight to the result and
// return 0 with out_of_range set.
// When n lies beyond the last built row, each missing row r is built first:
// one read and one write per inner entry, no read for the last one since its
// upper neighbor is the row edge; then a lookup read and the result.
// Only inner entries are stored; row edges are answered as 1 directly.
// Reset: only row 0 counts as built; the memory needs no clearing pass.
module binomial_coefficient_table #(
  parameter int MAX_ROW = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bct_pkg::bct_in_t  in_data,
  output logic              out_valid,
  output bct_pkg::bct_out_t out_data
);
  import bct_pkg::*;

  localparam int TABLE_DEPTH = (MAX_ROW + 1) * (MAX_ROW + 2) / 2;
  localparam logic [IDX_W-1:0] MAX_ROW_IDX = IDX_W'(MAX_ROW);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROW    = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_r, state_nxt;
  bct_in_t    req_r, req_nxt;
  logic [5:0] rows_filled_r, rows_filled_nxt;
  addr_t      fill_base_r, fill_base_nxt;   // base address of last built row
  logic [5:0] r_r, r_nxt;                   // row under construction
  logic [5:0] j_r, j_nxt;                   // inner entry index
  coef_t      left_r, left_nxt;
  logic       edge_r, edge_nxt;
  logic       one_r, one_nxt;
  logic       err_r, err_nxt;

  bct_mem_req_t mreq;
  coef_t        rdata;
  coef_t        right_val;

  logic          accept;
  logic          in_bad;
  logic [13:0]   in_prod, rq_prod;
  addr_t         in_addr, rq_addr;

  bct_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign in_bad = (in_data.column > in_data.row) || (in_data.row > MAX_ROW_IDX);

  // Row base n*(n+1)/2 plus column
  assign in_prod = {7'b0, in_data.row} * ({7'b0, in_data.row} + 14'd1);
  assign in_addr = ADDR_W'(in_prod >> 1) + ADDR_W'(in_data.column);
  assign rq_prod = {7'b0, req_r.row} * ({7'b0, req_r.row} + 14'd1);
  assign rq_addr = ADDR_W'(rq_prod >> 1) + ADDR_W'(req_r.column);

  assign right_val = edge_r ? COEF_W'(1) : rdata;

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    rows_filled_nxt = rows_filled_r;
    fill_base_nxt   = fill_base_r;
    r_nxt           = r_r;
    j_nxt           = j_r;
    left_nxt        = left_r;
    edge_nxt        = edge_r;
    one_nxt         = one_r;
    err_nxt         = err_r;
    mreq            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          err_nxt = 1'b0;
          one_nxt = (in_data.column == '0) || (in_data.column == in_data.row);
          if (in_bad) begin
            err_nxt   = 1'b1;
            state_nxt = S_RESP;
          end else if ({1'b0, rows_filled_r} < in_data.row) begin
            r_nxt     = rows_filled_r + 6'd1;
            j_nxt     = 6'd1;
            left_nxt  = COEF_W'(1);
            state_nxt = S_ROW;
          end else begin
            mreq.re    = 1'b1;
            mreq.raddr = in_addr;
            state_nxt  = S_RESP;
          end
        end
      end

      S_ROW: begin
        if (j_r >= r_r) begin
          // Row complete: advance the built-row marker
          rows_filled_nxt = r_r;
          fill_base_nxt   = fill_base_r + ADDR_W'(r_r);
          if ({1'b0, r_r} == req_r.row) begin
            state_nxt = S_LOOKUP;
          end else begin
            r_nxt    = r_r + 6'd1;
            j_nxt    = 6'd1;
            left_nxt = COEF_W'(1);
          end
        end else begin
          // The last neighbor above is the row edge, which is never stored
          edge_nxt   = (j_r == 6'(r_r - 6'd1));
          mreq.re    = (j_r != 6'(r_r - 6'd1));
          mreq.raddr = fill_base_r + ADDR_W'(j_r);
          state_nxt  = S_WRITE;
        end
      end

      S_WRITE: begin
        mreq.we    = 1'b1;
        mreq.waddr = fill_base_r + ADDR_W'(r_r) + ADDR_W'(j_r);
        mreq.wdata = left_r + right_val;
        left_nxt   = right_val;
        j_nxt      = j_r + 6'd1;
        state_nxt  = S_ROW;
      end

      S_LOOKUP: begin
        mreq.re    = 1'b1;
        mreq.raddr = rq_addr;
        state_nxt  = S_RESP;
      end

      S_RESP: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rows_filled_r <= '0;
      fill_base_r   <= '0;
    end else begin
      state_r       <= state_nxt;
      rows_filled_r <= rows_filled_nxt;
      fill_base_r   <= fill_base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    r_r    <= r_nxt;
    j_r    <= j_nxt;
    left_r <= left_nxt;
    edge_r <= edge_nxt;
    one_r  <= one_nxt;
    err_r  <= err_nxt;
  end

  assign out_valid = (state_r == S_RESP);

  always_comb begin
    if (err_r) begin
      out_data = '{coefficient: '0, out_of_range: 1'b1};
    end else if (one_r) begin
      out_data = '{coefficient: COEF_W'(1), out_of_range: 1'b0};
    end else begin
      out_data = '{coefficient: rdata, out_of_range: 1'b0};
    end
  end

  a_no_back_to_back_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_error_returns_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_of_range) |-> (out_data.coefficient == '0))
    else $error("out-of-range result carries nonzero coefficient");

  a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, rows_filled_r} <= MAX_ROW_IDX)
    else $error("built rows exceed table size");

  a_build_never_writes_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (j_r != '0) && (j_r < r_r))
    else $error("row build wrote outside the inner entries");

endmodule

[sv/bct_ram.sv]
// Coefficient storage: one write port, one read port, registered read data.
// Depends on bct_pkg for the memory request struct and coefficient type.
module bct_ram #(
  parameter int DEPTH = 861
) (
  input  logic                clk,
  input  bct_pkg::bct_mem_req_t req,
  output bct_pkg::coef_t      rdata
);
  import bct_pkg::*;

  localparam int AW = $clog2(DEPTH);

  coef_t mem [DEPTH];
  coef_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule
